### hdl/jdse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdse_pkg
// Shared types, direction codes and fixed-point constants of the joystick
// direction and speed encoder.
// ----------------------------------------------------------------------------
package jdse_pkg;

	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned SWITCH_W = 8;
	localparam int unsigned DIR_W    = 4;
	localparam int unsigned SPEED_W  = 7;
	localparam int unsigned DEFL_W   = 16;
	localparam int unsigned RECIP_W  = 15;
	localparam int unsigned RECIP_SH = 20;

	// direction codes
	localparam logic [DIR_W-1:0] DIR_STOP       = 4'd0;
	localparam logic [DIR_W-1:0] DIR_FWD        = 4'd1;
	localparam logic [DIR_W-1:0] DIR_BACK       = 4'd2;
	localparam logic [DIR_W-1:0] DIR_LEFT       = 4'd3;
	localparam logic [DIR_W-1:0] DIR_RIGHT      = 4'd4;
	localparam logic [DIR_W-1:0] DIR_FWD_LEFT   = 4'd5;
	localparam logic [DIR_W-1:0] DIR_FWD_RIGHT  = 4'd6;
	localparam logic [DIR_W-1:0] DIR_BACK_LEFT  = 4'd7;
	localparam logic [DIR_W-1:0] DIR_BACK_RIGHT = 4'd8;
	localparam logic [DIR_W-1:0] DIR_ROT_LEFT   = 4'd9;
	localparam logic [DIR_W-1:0] DIR_ROT_RIGHT  = 4'd10;

	// voltage in hundredths is raw * SCALE_NUM / SCALE_DEN
	localparam int unsigned SCALE_NUM = 330;
	localparam int unsigned SCALE_DEN = 4096;
	localparam int unsigned DZ_LO     = 105;
	localparam int unsigned DZ_HI     = 145;
	localparam int unsigned DIAG_X    = 130;
	localparam int unsigned FULL_PCT  = 100;

	// thresholds moved onto the raw sample scale
	localparam logic [SAMPLE_W-1:0] LO_BELOW_MAX =
		SAMPLE_W'((DZ_LO * SCALE_DEN - 1) / SCALE_NUM);
	localparam logic [SAMPLE_W-1:0] LO_ABOVE_MIN =
		SAMPLE_W'((DZ_LO * SCALE_DEN) / SCALE_NUM + 1);
	localparam logic [SAMPLE_W-1:0] HI_BELOW_MAX =
		SAMPLE_W'((DZ_HI * SCALE_DEN - 1) / SCALE_NUM);
	localparam logic [SAMPLE_W-1:0] HI_ABOVE_MIN =
		SAMPLE_W'((DZ_HI * SCALE_DEN) / SCALE_NUM + 1);
	localparam logic [SAMPLE_W-1:0] DIAG_ABOVE_MIN =
		SAMPLE_W'((DIAG_X * SCALE_DEN) / SCALE_NUM + 1);

	// deflection times 100, still on the 1/4096 scale
	localparam int unsigned PROD_W   = 28;
	localparam logic [PROD_W-1:0] PCT_MUL   = PROD_W'(SCALE_NUM * FULL_PCT);
	localparam logic [PROD_W-1:0] LO_SCALED = PROD_W'(DZ_LO * SCALE_DEN * FULL_PCT);
	localparam logic [PROD_W-1:0] HI_SCALED = PROD_W'(DZ_HI * SCALE_DEN * FULL_PCT);

	// spans, their reciprocals and the saturation limits
	localparam int unsigned SPAN_43 = 43;
	localparam int unsigned SPAN_50 = 50;
	localparam int unsigned SPAN_52 = 52;
	localparam int unsigned SPAN_78 = 78;
	localparam int unsigned SPAN_80 = 80;

	localparam logic [RECIP_W-1:0] RECIP_43 =
		RECIP_W'(((1 << RECIP_SH) + SPAN_43 - 1) / SPAN_43);
	localparam logic [RECIP_W-1:0] RECIP_50 =
		RECIP_W'(((1 << RECIP_SH) + SPAN_50 - 1) / SPAN_50);
	localparam logic [RECIP_W-1:0] RECIP_52 =
		RECIP_W'(((1 << RECIP_SH) + SPAN_52 - 1) / SPAN_52);
	localparam logic [RECIP_W-1:0] RECIP_78 =
		RECIP_W'(((1 << RECIP_SH) + SPAN_78 - 1) / SPAN_78);
	localparam logic [RECIP_W-1:0] RECIP_80 =
		RECIP_W'(((1 << RECIP_SH) + SPAN_80 - 1) / SPAN_80);

	localparam logic [DEFL_W-1:0] SAT_43 = DEFL_W'((FULL_PCT + 1) * SPAN_43);
	localparam logic [DEFL_W-1:0] SAT_50 = DEFL_W'((FULL_PCT + 1) * SPAN_50);
	localparam logic [DEFL_W-1:0] SAT_52 = DEFL_W'((FULL_PCT + 1) * SPAN_52);
	localparam logic [DEFL_W-1:0] SAT_78 = DEFL_W'((FULL_PCT + 1) * SPAN_78);
	localparam logic [DEFL_W-1:0] SAT_80 = DEFL_W'((FULL_PCT + 1) * SPAN_80);
	localparam logic [DEFL_W-1:0] SAT_NONE = '1;

	localparam logic [SPEED_W-1:0] SPEED_FULL = SPEED_W'(FULL_PCT);

	// classification result handed to the speed stage
	typedef struct packed {
		logic [DIR_W-1:0]  code;
		logic              nomatch;
		logic [DEFL_W-1:0] defl;
	} cls_t;

endpackage

### hdl/jdse_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdse_in_if / jdse_out_if
// Valid/ready channels carrying joystick sample words and encoded frames.
// ----------------------------------------------------------------------------
interface jdse_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] x_sample;
	logic [11:0] y_sample;
	logic [11:0] z_sample;
	logic [7:0]  switch_bits;

	modport source (output valid, x_sample, y_sample, z_sample, switch_bits,
		input ready);
	modport sink (input valid, x_sample, y_sample, z_sample, switch_bits,
		output ready);
endinterface

interface jdse_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] direction_code;
	logic [6:0] speed_percent;
	logic [7:0] switch_byte;

	modport source (output valid, direction_code, speed_percent, switch_byte,
		input ready);
	modport sink (input valid, direction_code, speed_percent, switch_byte,
		output ready);
endinterface

### hdl/joystick_direction_speed_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_direction_speed_encoder_top
// Turns joystick axis samples and switch bits into direction/speed frames.
// ----------------------------------------------------------------------------
// joy carries one word per sample set: x, y and z axis samples and the switch
// byte. A word equal to the last accepted one is dropped; any other word
// yields one frame on frame: direction code, speed percentage and the switch
// byte. Frames come out in order: the input register loads at the accepting
// edge, then the classification register, then the output register. The speed
// reciprocal multiply sits between the last two. While the receiver keeps up,
// one word is accepted per cycle. When the receiver stalls with a frame
// waiting, the whole pipeline holds and joy.ready drops in the same cycle.
// Reset empties the pipeline and clears the last sample set and the held
// direction and speed to zero, so an all-zero first word gives no frame.
// ----------------------------------------------------------------------------
module joystick_direction_speed_encoder_top
	import jdse_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	jdse_in_if.sink        joy,
	jdse_out_if.source     frame
);

	logic adv;
	logic changed;

	logic [SAMPLE_W-1:0] last_x_q, last_y_q, last_z_q;
	logic [SWITCH_W-1:0] last_sw_q;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] x_s1, y_s1, z_s1;
	logic [SWITCH_W-1:0] sw_s1;

	cls_t                cls_c;
	logic                valid_s2;
	cls_t                cls_s2;
	logic [SWITCH_W-1:0] sw_s2;

	logic [SPEED_W-1:0]  speed_c;
	logic [DIR_W-1:0]    dir_c;
	logic [SPEED_W-1:0]  spd_c;

	logic                out_valid_q;
	logic [DIR_W-1:0]    dir_q;
	logic [SPEED_W-1:0]  speed_q;
	logic [SWITCH_W-1:0] sw_q;
	logic [DIR_W-1:0]    held_dir_q;
	logic [SPEED_W-1:0]  held_speed_q;

	assign adv       = !out_valid_q || frame.ready;
	assign joy.ready = adv;
	assign changed   = (joy.x_sample != last_x_q) || (joy.y_sample != last_y_q) ||
		(joy.z_sample != last_z_q) || (joy.switch_bits != last_sw_q);

	// change detection and input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q  <= '0;
			last_y_q  <= '0;
			last_z_q  <= '0;
			last_sw_q <= '0;
			valid_s1  <= 1'b0;
		end else if (adv) begin
			valid_s1 <= joy.valid && changed;
			if (joy.valid) begin
				last_x_q  <= joy.x_sample;
				last_y_q  <= joy.y_sample;
				last_z_q  <= joy.z_sample;
				last_sw_q <= joy.switch_bits;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1  <= joy.x_sample;
			y_s1  <= joy.y_sample;
			z_s1  <= joy.z_sample;
			sw_s1 <= joy.switch_bits;
		end
	end

	jdse_classify u_classify (
		.x   (x_s1),
		.y   (y_s1),
		.z   (z_s1),
		.cls (cls_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s2 <= cls_c;
			sw_s2  <= sw_s1;
		end
	end

	jdse_speed u_speed (
		.code  (cls_s2.code),
		.defl  (cls_s2.defl),
		.speed (speed_c)
	);

	// no branch matched: repeat the held direction and speed
	assign dir_c = cls_s2.nomatch ? held_dir_q : cls_s2.code;
	assign spd_c = cls_s2.nomatch ? held_speed_q : speed_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			held_dir_q   <= DIR_STOP;
			held_speed_q <= '0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
			if (valid_s2) begin
				held_dir_q   <= dir_c;
				held_speed_q <= spd_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dir_q   <= dir_c;
			speed_q <= spd_c;
			sw_q    <= sw_s2;
		end
	end

	assign frame.valid          = out_valid_q;
	assign frame.direction_code = dir_q;
	assign frame.speed_percent  = speed_q;
	assign frame.switch_byte    = sw_q;

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> speed_q <= SPEED_FULL)
		else $error("speed above full scale");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> dir_q <= DIR_ROT_RIGHT)
		else $error("direction code out of range");

	a_stop_speed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !cls_s2.nomatch && cls_s2.code == DIR_STOP |-> spd_c == '0)
		else $error("stop with nonzero speed");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !adv |=> valid_s2 && $stable(cls_s2))
		else $error("classified word lost during stall");

	a_held_update: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s2 |=> held_dir_q == dir_q && held_speed_q == speed_q)
		else $error("held state out of step with output");

endmodule

### hdl/jdse_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdse_classify
// Dead-zone priority chain and deflection beyond the threshold, scaled by 100
// on the 1/4096 voltage grid.
// ----------------------------------------------------------------------------
module jdse_classify
	import jdse_pkg::*;
(
	input  logic [SAMPLE_W-1:0] x,
	input  logic [SAMPLE_W-1:0] y,
	input  logic [SAMPLE_W-1:0] z,
	output cls_t                cls
);

	logic x_lo, x_hi, x_diag, x_in;
	logic y_lo, y_hi, y_in;
	logic z_lo, z_hi, z_in;
	logic [SAMPLE_W-1:0] raw_sel;
	logic up, zero;
	logic [PROD_W-1:0] scaled, diff;

	assign x_lo   = x <= LO_BELOW_MAX;
	assign x_hi   = x >= HI_ABOVE_MIN;
	assign x_diag = x >= DIAG_ABOVE_MIN;
	assign x_in   = x inside {[LO_ABOVE_MIN:HI_BELOW_MAX]};
	assign y_lo   = y <= LO_BELOW_MAX;
	assign y_hi   = y >= HI_ABOVE_MIN;
	assign y_in   = y inside {[LO_ABOVE_MIN:HI_BELOW_MAX]};
	assign z_lo   = z <= LO_BELOW_MAX;
	assign z_hi   = z >= HI_ABOVE_MIN;
	assign z_in   = z inside {[LO_ABOVE_MIN:HI_BELOW_MAX]};

	always_comb begin
		cls.code    = DIR_STOP;
		cls.nomatch = 1'b0;
		raw_sel     = y;
		up          = 1'b1;
		zero        = 1'b0;
		if (x_lo && y_hi) begin
			cls.code = DIR_FWD_LEFT;
		end else if (x_diag && y_hi) begin
			cls.code = DIR_FWD_RIGHT;
		end else if (x_lo && y_lo) begin
			cls.code = DIR_BACK_LEFT;
			up = 1'b0;
		end else if (x_hi && y_lo) begin
			cls.code = DIR_BACK_RIGHT;
			up = 1'b0;
		end else if (x_lo) begin
			cls.code = DIR_LEFT;
			raw_sel = x;
			up = 1'b0;
		end else if (x_hi) begin
			cls.code = DIR_RIGHT;
			raw_sel = x;
		end else if (y_hi) begin
			cls.code = DIR_FWD;
		end else if (y_lo) begin
			cls.code = DIR_BACK;
			up = 1'b0;
		end else if (z_lo) begin
			cls.code = DIR_ROT_LEFT;
			raw_sel = z;
			up = 1'b0;
		end else if (z_hi) begin
			cls.code = DIR_ROT_RIGHT;
			raw_sel = z;
		end else if (x_in || y_in || z_in) begin
			zero = 1'b1;
		end else begin
			cls.nomatch = 1'b1;
			zero = 1'b1;
		end
	end

	assign scaled   = PROD_W'(raw_sel) * PCT_MUL;
	assign diff     = up ? (scaled - HI_SCALED) : (LO_SCALED - scaled);
	assign cls.defl = zero ? '0 : diff[PROD_W-1 -: DEFL_W];

endmodule

### hdl/jdse_speed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdse_speed
// Speed percentage: deflection divided by the span of the direction by a
// reciprocal multiply, saturated at 100.
// ----------------------------------------------------------------------------
module jdse_speed
	import jdse_pkg::*;
(
	input  logic [DIR_W-1:0]   code,
	input  logic [DEFL_W-1:0]  defl,
	output logic [SPEED_W-1:0] speed
);

	localparam int unsigned SMALL_W = 13;
	localparam int unsigned MUL_W   = SMALL_W + RECIP_W;

	logic [RECIP_W-1:0] recip;
	logic [DEFL_W-1:0]  sat_lim;
	logic [MUL_W-1:0]   prod;
	logic [MUL_W-RECIP_SH-1:0] quot;

	always_comb begin
		case (code)
			DIR_FWD_LEFT, DIR_FWD: begin
				recip = RECIP_52;
				sat_lim = SAT_52;
			end
			DIR_FWD_RIGHT: begin
				recip = RECIP_43;
				sat_lim = SAT_43;
			end
			DIR_BACK_LEFT, DIR_BACK_RIGHT: begin
				recip = RECIP_50;
				sat_lim = SAT_50;
			end
			DIR_LEFT, DIR_RIGHT: begin
				recip = RECIP_78;
				sat_lim = SAT_78;
			end
			DIR_BACK, DIR_ROT_LEFT, DIR_ROT_RIGHT: begin
				recip = RECIP_80;
				sat_lim = SAT_80;
			end
			default: begin
				recip = '0;
				sat_lim = SAT_NONE;
			end
		endcase
	end

	// below the saturation limit the deflection fits in 13 bits
	assign prod  = MUL_W'(defl[SMALL_W-1:0]) * MUL_W'(recip);
	assign quot  = prod[MUL_W-1:RECIP_SH];
	assign speed = (defl >= sat_lim) ? SPEED_FULL : quot[SPEED_W-1:0];

endmodule

### bench/tb_joystick_direction_speed_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joystick_direction_speed_encoder_top
// Self-checking bench for the joystick encoder. A tracker class holds its own
// copy of the last sample set and of the held direction and speed. For every
// accepted joystick word it works out the frame to expect, and it compares
// each accepted frame with the oldest one due. Directed words cover the
// thresholds of every axis and every direction. Random words are weighted
// toward the dead-zone edges and include repeated words, which give no frame.
// Both sides idle in random bursts. Once the receiver holds off long enough
// to back the pipeline up, and twice the sender waits for the pipeline to
// drain.
// ----------------------------------------------------------------------------
module tb_joystick_direction_speed_encoder_top;
	import jdse_pkg::*;

	typedef struct packed {
		logic [DIR_W-1:0]   dir;
		logic [SPEED_W-1:0] speed;
		logic [SWITCH_W-1:0] sw;
	} frame_t;

	class joy_frame_tracker;
		logic [SAMPLE_W-1:0] last_x, last_y, last_z;
		logic [SWITCH_W-1:0] last_sw;
		logic [DIR_W-1:0]    kept_dir;
		logic [SPEED_W-1:0]  kept_speed;
		frame_t              frames_due[$];
		int                  mismatches;
		int                  frames_seen;
		int                  repeats_dropped;
		int                  dir_hits[16];

		function new();
			last_x = '0;
			last_y = '0;
			last_z = '0;
			last_sw = '0;
			kept_dir = DIR_STOP;
			kept_speed = '0;
			mismatches = 0;
			frames_seen = 0;
			repeats_dropped = 0;
			foreach (dir_hits[i])
				dir_hits[i] = 0;
		endfunction

		function int pending();
			return frames_due.size();
		endfunction

		function bit over(logic [SAMPLE_W-1:0] raw, int unsigned t);
			return 64'(raw) * SCALE_NUM > 64'(t) * SCALE_DEN;
		endfunction

		function bit under(logic [SAMPLE_W-1:0] raw, int unsigned t);
			return 64'(raw) * SCALE_NUM < 64'(t) * SCALE_DEN;
		endfunction

		function logic [SPEED_W-1:0] pct_of(longint unsigned defl, int unsigned span);
			longint unsigned q;
			q = defl * FULL_PCT / (64'(SCALE_DEN) * span);
			return (q > FULL_PCT) ? SPEED_FULL : SPEED_W'(q);
		endfunction

		function logic [SPEED_W-1:0] pct_up(logic [SAMPLE_W-1:0] raw, int unsigned t,
				int unsigned span);
			return pct_of(64'(raw) * SCALE_NUM - 64'(t) * SCALE_DEN, span);
		endfunction

		function logic [SPEED_W-1:0] pct_down(logic [SAMPLE_W-1:0] raw, int unsigned t,
				int unsigned span);
			return pct_of(64'(t) * SCALE_DEN - 64'(raw) * SCALE_NUM, span);
		endfunction

		function bit in_dead_zone(logic [SAMPLE_W-1:0] raw);
			return over(raw, DZ_LO) && under(raw, DZ_HI);
		endfunction

		function void note_word(logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] y,
				logic [SAMPLE_W-1:0] z, logic [SWITCH_W-1:0] sw);
			frame_t f;
			if (x == last_x && y == last_y && z == last_z && sw == last_sw) begin
				repeats_dropped++;
				return;
			end
			last_x = x;
			last_y = y;
			last_z = z;
			last_sw = sw;
			if (under(x, DZ_LO) && over(y, DZ_HI)) begin
				kept_dir = DIR_FWD_LEFT;
				kept_speed = pct_up(y, DZ_HI, SPAN_52);
			end else if (over(x, DIAG_X) && over(y, DZ_HI)) begin
				kept_dir = DIR_FWD_RIGHT;
				kept_speed = pct_up(y, DZ_HI, SPAN_43);
			end else if (under(x, DZ_LO) && under(y, DZ_LO)) begin
				kept_dir = DIR_BACK_LEFT;
				kept_speed = pct_down(y, DZ_LO, SPAN_50);
			end else if (over(x, DZ_HI) && under(y, DZ_LO)) begin
				kept_dir = DIR_BACK_RIGHT;
				kept_speed = pct_down(y, DZ_LO, SPAN_50);
			end else if (under(x, DZ_LO)) begin
				kept_dir = DIR_LEFT;
				kept_speed = pct_down(x, DZ_LO, SPAN_78);
			end else if (over(x, DZ_HI)) begin
				kept_dir = DIR_RIGHT;
				kept_speed = pct_up(x, DZ_HI, SPAN_78);
			end else if (over(y, DZ_HI)) begin
				kept_dir = DIR_FWD;
				kept_speed = pct_up(y, DZ_HI, SPAN_52);
			end else if (under(y, DZ_LO)) begin
				kept_dir = DIR_BACK;
				kept_speed = pct_down(y, DZ_LO, SPAN_80);
			end else if (under(z, DZ_LO)) begin
				kept_dir = DIR_ROT_LEFT;
				kept_speed = pct_down(z, DZ_LO, SPAN_80);
			end else if (over(z, DZ_HI)) begin
				kept_dir = DIR_ROT_RIGHT;
				kept_speed = pct_up(z, DZ_HI, SPAN_80);
			end else if (in_dead_zone(x) || in_dead_zone(y) || in_dead_zone(z)) begin
				kept_dir = DIR_STOP;
				kept_speed = '0;
			end
			// a value exactly on a threshold matches nothing: held values go out again
			f.dir = kept_dir;
			f.speed = kept_speed;
			f.sw = sw;
			frames_due.push_back(f);
		endfunction

		task report_mismatch(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		task check_frame(logic [DIR_W-1:0] dir, logic [SPEED_W-1:0] speed,
				logic [SWITCH_W-1:0] sw);
			frame_t f;
			frames_seen++;
			dir_hits[dir]++;
			if (frames_due.size() == 0) begin
				report_mismatch($sformatf("frame dir %0d speed %0d sw %02h with none due",
					dir, speed, sw));
				return;
			end
			f = frames_due.pop_front();
			if (dir !== f.dir)
				report_mismatch($sformatf("direction %0d, expected %0d", dir, f.dir));
			if (speed !== f.speed)
				report_mismatch($sformatf("speed %0d, expected %0d (dir %0d)", speed,
					f.speed, f.dir));
			if (sw !== f.sw)
				report_mismatch($sformatf("switch byte %02h, expected %02h", sw, f.sw));
		endtask
	endclass

	localparam int LONG_HOLD = 200;

	logic clk;
	logic arst_n;

	jdse_in_if  joy ();
	jdse_out_if frame ();

	joystick_direction_speed_encoder_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.joy    (joy),
		.frame  (frame)
	);

	joy_frame_tracker tracker = new();

	bit idle_on;
	bit long_hold_req;
	int words_in;
	logic [SAMPLE_W-1:0] sent_x, sent_y, sent_z;
	logic [SWITCH_W-1:0] sent_sw;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("joystick_direction_speed_encoder_top regression: fail");
		$finish;
	end

	// accepted words and frames
	always @(posedge clk) begin
		if (arst_n) begin
			if (joy.valid && joy.ready) begin
				words_in++;
				tracker.note_word(joy.x_sample, joy.y_sample, joy.z_sample,
					joy.switch_bits);
			end
			if (frame.valid && frame.ready)
				tracker.check_frame(frame.direction_code, frame.speed_percent,
					frame.switch_byte);
		end
	end

	// receiver
	initial begin
		frame.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				frame.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_req = 1'b0;
				frame.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				frame.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				frame.ready <= 1'b1;
			end else begin
				frame.ready <= 1'b1;
			end
		end
	end

	// called right after a falling edge, returns right after one
	task automatic send_word(logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] y,
			logic [SAMPLE_W-1:0] z, logic [SWITCH_W-1:0] sw);
		joy.valid <= 1'b1;
		joy.x_sample <= x;
		joy.y_sample <= y;
		joy.z_sample <= z;
		joy.switch_bits <= sw;
		sent_x = x;
		sent_y = y;
		sent_z = z;
		sent_sw = sw;
		do
			@(posedge clk);
		while (!joy.ready);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			joy.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_axis();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
			1, 2: return 12'($urandom_range(1285, 1320));
			3, 4: return 12'($urandom_range(1785, 1815));
			5: return 12'($urandom_range(1600, 1630));
			6, 7: return 12'($urandom_range(1304, 1799));
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic send_random();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			send_word(sent_x, sent_y, sent_z, sent_sw);
		else if (pick == 1)
			send_word(sent_x, sent_y, sent_z, 8'($urandom_range(0, 255)));
		else
			send_word(pick_axis(), pick_axis(), pick_axis(), 8'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		joy.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int hit;
		arst_n = 1'b0;
		joy.valid = 1'b0;
		joy.x_sample = '0;
		joy.y_sample = '0;
		joy.z_sample = '0;
		joy.switch_bits = '0;
		idle_on = 1'b1;
		long_hold_req = 1'b0;
		words_in = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// all-zero word right after reset matches the cleared state
		send_word(12'd0, 12'd0, 12'd0, 8'h00);
		send_word(12'd0, 12'd4095, 12'd2048, 8'h01);
		send_word(12'd1303, 12'd1800, 12'd2048, 8'h01);
		send_word(12'd4095, 12'd4095, 12'd2048, 8'h02);
		send_word(12'd1614, 12'd1800, 12'd0, 8'h04);
		send_word(12'd1613, 12'd1800, 12'd0, 8'h08);
		send_word(12'd0, 12'd0, 12'd4095, 8'h10);
		send_word(12'd1303, 12'd1303, 12'd4095, 8'h20);
		send_word(12'd4095, 12'd0, 12'd1500, 8'h40);
		send_word(12'd1800, 12'd1303, 12'd1500, 8'h80);
		send_word(12'd1799, 12'd0, 12'd1500, 8'h00);
		send_word(12'd0, 12'd1500, 12'd1500, 8'h00);
		send_word(12'd1303, 12'd1500, 12'd1500, 8'h00);
		send_word(12'd1304, 12'd1500, 12'd1500, 8'h00);
		send_word(12'd4095, 12'd1500, 12'd1500, 8'h55);
		send_word(12'd1800, 12'd1799, 12'd1304, 8'hAA);
		send_word(12'd1500, 12'd4095, 12'd1500, 8'h00);
		send_word(12'd1500, 12'd0, 12'd1500, 8'h00);
		send_word(12'd1500, 12'd1500, 12'd0, 8'h00);
		send_word(12'd1500, 12'd1500, 12'd1303, 8'h00);
		send_word(12'd1500, 12'd1500, 12'd4095, 8'h00);
		send_word(12'd1500, 12'd1500, 12'd1800, 8'h00);
		send_word(12'd1500, 12'd1500, 12'd1799, 8'h00);
		send_word(12'd1500, 12'd1500, 12'd1799, 8'h00);
		send_word(12'd1500, 12'd1500, 12'd1799, 8'hFF);

		repeat (140) send_random();

		// receiver holds off while words keep coming
		long_hold_req = 1'b1;
		idle_on = 1'b0;
		repeat (40) send_random();
		idle_on = 1'b1;

		drain();
		repeat (110) send_random();

		// last stretch at full rate on both sides
		idle_on = 1'b0;
		repeat (110) send_random();
		drain();
		repeat (10) @(posedge clk);

		hit = 0;
		for (int d = 0; d <= 10; d++)
			if (tracker.dir_hits[d] != 0)
				hit++;
		$display("%0d words accepted, %0d repeats dropped, %0d frames checked",
			words_in, tracker.repeats_dropped, tracker.frames_seen);
		$display("%0d of 11 direction codes seen, long receiver stall and drain pause done",
			hit);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("joystick_direction_speed_encoder_top regression: pass");
		else
			$display("joystick_direction_speed_encoder_top regression: fail");
		$finish;
	end

endmodule
